/* rtl/core/esp_pkg.sv */
// Shared types, constants and the control program of the encoder speed PID.
`timescale 1ns / 1ps

package esp_pkg;

   // Datapath operations selected by one control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_DELTA,
      OP_MUL_SCALE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ERR,
      OP_SUM,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_D,
      OP_ACC,
      OP_ROUND,
      OP_FINISH,
      OP_CLEAR,
      OP_IGNORE
   } op_type;

   // Jump conditions of the sequencer.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_INVALID,
      COND_RESET,
      COND_TICKS_ZERO,
      COND_DIV_MORE
   } cond_type;

   localparam int PC_W = 4;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            last;
   } ctrl_word_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   localparam int DIVIDEND_W = 56;
   localparam int DIVISOR_W  = 24;
   localparam int DIV_CNT_W  = 6;

   // Register indexes on the write port.
   localparam logic [1:0] CSR_GAIN_PROP   = 2'd0;
   localparam logic [1:0] CSR_GAIN_INTEG  = 2'd1;
   localparam logic [1:0] CSR_GAIN_DERIV  = 2'd2;
   localparam logic [1:0] CSR_SPEED_SCALE = 2'd3;

   localparam logic [15:0] GAIN_PROP_RESET   = 16'd1843;
   localparam logic [15:0] GAIN_INTEG_RESET  = 16'd205;
   localparam logic [15:0] GAIN_DERIV_RESET  = 16'd819;
   localparam logic [23:0] SPEED_SCALE_RESET = 24'd6338830;

   // Program addresses that are jump targets.
   localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd5;
   localparam logic [PC_W-1:0] PC_ERR      = 4'd6;
   localparam logic [PC_W-1:0] PC_CLEAR    = 4'd14;
   localparam logic [PC_W-1:0] PC_IGNORE   = 4'd15;

   function automatic ctrl_word_type microcode(input logic [PC_W-1:0] pc);
      ctrl_word_type word;
      case (pc)
         4'd0:    word = '{OP_NOP,       COND_INVALID,    PC_IGNORE,   1'b0};
         4'd1:    word = '{OP_NOP,       COND_RESET,      PC_CLEAR,    1'b0};
         4'd2:    word = '{OP_DELTA,     COND_NEVER,      '0,          1'b0};
         4'd3:    word = '{OP_MUL_SCALE, COND_TICKS_ZERO, PC_ERR,      1'b0};
         4'd4:    word = '{OP_DIV_INIT,  COND_NEVER,      '0,          1'b0};
         4'd5:    word = '{OP_DIV_STEP,  COND_DIV_MORE,   PC_DIV_STEP, 1'b0};
         4'd6:    word = '{OP_ERR,       COND_NEVER,      '0,          1'b0};
         4'd7:    word = '{OP_SUM,       COND_NEVER,      '0,          1'b0};
         4'd8:    word = '{OP_MUL_P,     COND_NEVER,      '0,          1'b0};
         4'd9:    word = '{OP_MUL_I,     COND_NEVER,      '0,          1'b0};
         4'd10:   word = '{OP_MUL_D,     COND_NEVER,      '0,          1'b0};
         4'd11:   word = '{OP_ACC,       COND_NEVER,      '0,          1'b0};
         4'd12:   word = '{OP_ROUND,     COND_NEVER,      '0,          1'b0};
         4'd13:   word = '{OP_FINISH,    COND_NEVER,      '0,          1'b1};
         4'd14:   word = '{OP_CLEAR,     COND_NEVER,      '0,          1'b1};
         4'd15:   word = '{OP_IGNORE,    COND_NEVER,      '0,          1'b1};
         default: word = '{OP_IGNORE,    COND_NEVER,      '0,          1'b1};
      endcase
      return word;
   endfunction

endpackage

/* rtl/core/esp_divider.sv */
// Restoring unsigned divider that retires one quotient bit per step.
`timescale 1ns / 1ps

module esp_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  esp_pkg::div_ctrl_type              ctrl,
   input  logic [esp_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [esp_pkg::DIVISOR_W-1:0]      divisor,
   output logic [esp_pkg::DIVIDEND_W-1:0]     quotient,
   output logic                               last
);
   import esp_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, divisor};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctrl.init) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(DIVIDEND_W);
      end else if (ctrl.step) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign last     = cnt_ff == DIV_CNT_W'(1);

endmodule

/* rtl/core/encoder_speed_pid.sv */
// Top level of the encoder speed PID: microcoded sequencer, datapath and motor state.
`timescale 1ns / 1ps
//
// Speed PID for up to MOTOR_COUNT wheel motors. Each request transaction names a
// motor and carries the target speed, the raw encoder count and the timer ticks
// since that motor's previous step. Each request yields exactly one response
// transaction with the corrected drive speed and two flags.
// The csr_ port writes the gains and the speed scale; write it only while idle.
// A short program in a read-only table sequences one shared multiplier, an
// adder/clamp datapath and a one-bit-per-cycle divider. A control step runs
// the 56 divider steps between the speed scaling and the error step; with zero
// elapsed ticks the divider is skipped. A reset command jumps to the clear step
// and an out-of-range motor to the ignore step.
// req_stall is high while a transaction is in the sequencer, so one item is in
// work at a time. The step that loads the response also clears the busy flag,
// and only then can the next request be taken. The response sits in an output
// register: a new request is taken while an earlier response still waits, and
// the finishing step holds while rsp_stall keeps a previous response in place,
// which adds the stalled cycles to the item.
// Synchronous reset loads the register defaults, clears every motor's count,
// error sum and previous error, and empties the sequencer and output register.

module encoder_speed_pid #(
   parameter int MOTOR_COUNT = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [1:0]         req_motor_select,
   input  logic signed [15:0] req_target_speed,
   input  logic [31:0]        req_encoder_count,
   input  logic [23:0]        req_elapsed_ticks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_drive_speed,
   output logic               rsp_saturated,
   output logic               rsp_bad_time,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import esp_pkg::*;

   localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [3:0] MOTOR_LIMIT = 4'(MOTOR_COUNT);

   // Configuration registers.
   logic [15:0] gain_prop_ff, gain_prop_in;
   logic [15:0] gain_integ_ff, gain_integ_in;
   logic [15:0] gain_deriv_ff, gain_deriv_in;
   logic [23:0] speed_scale_ff, speed_scale_in;

   // Per-motor loop state.
   logic [31:0]        last_count_ff [MOTOR_COUNT];
   logic [31:0]        last_count_in [MOTOR_COUNT];
   logic signed [31:0] error_sum_ff  [MOTOR_COUNT];
   logic signed [31:0] error_sum_in  [MOTOR_COUNT];
   logic signed [16:0] last_error_ff [MOTOR_COUNT];
   logic signed [16:0] last_error_in [MOTOR_COUNT];

   // Sequencer.
   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ctrl_word_type   cw;
   logic            taken;
   logic            advance;
   logic            out_free;
   logic            req_accept;

   // Captured transaction.
   logic               cmd_ff, cmd_in;
   logic               sel_ok_ff, sel_ok_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [15:0] target_ff, target_in;
   logic [31:0]        enc_ff, enc_in;
   logic [23:0]        ticks_ff, ticks_in;
   logic               bad_ff, bad_in;
   logic [3:0]         sel_ext;

   // Datapath registers.
   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [16:0] err_ff, err_in;
   logic signed [31:0] sum_ff, sum_in;
   logic               sat_ff, sat_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_drive_ff, rsp_drive_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               rsp_bad_ff, rsp_bad_in;

   // Datapath combinational values.
   logic [31:0]        delta;
   logic [31:0]        quotient;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic               div_last;
   div_ctrl_type       div_ctrl;
   logic               q_big;
   logic [18:0]        q_sat;
   logic signed [19:0] meas;
   logic signed [20:0] err_raw;
   logic signed [32:0] sum_raw;
   logic signed [17:0] err_diff;
   logic signed [32:0] mul_a;
   logic signed [24:0] mul_b;
   logic signed [57:0] mul_p;
   logic signed [49:0] acc_sum;
   logic signed [38:0] drive_raw;
   logic signed [15:0] drive_sat;
   logic               drive_clamped;

   assign sel_ext    = {2'b00, req_motor_select};
   assign cw         = microcode(pc_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !busy_ff;
   assign req_stall  = busy_ff;

   esp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff[DIVIDEND_W-1:0]),
      .divisor  (ticks_ff),
      .quotient (div_quotient),
      .last     (div_last)
   );

   // Encoder change since the previous step, wrapped to 32 bits.
   assign delta = enc_ff - last_count_ff[idx_ff];

   // Any quotient of 2^18 or more drives the error into its clamp, so it is
   // reduced to that value before the subtraction.
   assign quotient = div_quotient[31:0];
   assign q_big    = |div_quotient[DIVIDEND_W-1:18];
   assign q_sat    = q_big ? 19'h40000 : quotient[18:0];
   assign meas     = bad_ff ? 20'sd0 :
                     (neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat}));
   assign err_raw  = {{5{target_ff[15]}}, target_ff} - {meas[19], meas};

   assign sum_raw  = {error_sum_ff[idx_ff][31], error_sum_ff[idx_ff]}
                   + {{16{err_ff[16]}}, err_ff};
   assign err_diff = {err_ff[16], err_ff}
                   - {last_error_ff[idx_ff][16], last_error_ff[idx_ff]};

   // One shared signed multiplier; operands follow the current operation.
   always_comb begin
      case (cw.op)
         OP_MUL_SCALE: begin
            mul_a = $signed({1'b0, mag_ff});
            mul_b = $signed({1'b0, speed_scale_ff});
         end
         OP_MUL_P: begin
            mul_a = {{16{err_ff[16]}}, err_ff};
            mul_b = $signed({9'd0, gain_prop_ff});
         end
         OP_MUL_I: begin
            mul_a = {sum_ff[31], sum_ff};
            mul_b = $signed({9'd0, gain_integ_ff});
         end
         OP_MUL_D: begin
            mul_a = {{15{err_diff[17]}}, err_diff};
            mul_b = $signed({9'd0, gain_deriv_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign acc_sum = acc_ff + prod_ff[49:0];

   // acc_ff already holds the rounding offset; the arithmetic shift is the floor.
   assign drive_raw = {{23{target_ff[15]}}, target_ff}
                    + {acc_ff[49], acc_ff[49:12]};
   always_comb begin
      drive_clamped = 1'b0;
      drive_sat     = drive_raw[15:0];
      if (drive_raw < -39'sd32768) begin
         drive_clamped = 1'b1;
         drive_sat     = 16'sh8000;
      end else if (drive_raw > 39'sd32767) begin
         drive_clamped = 1'b1;
         drive_sat     = 16'sh7FFF;
      end
   end

   always_comb begin
      case (cw.cond)
         COND_INVALID:    taken = !sel_ok_ff;
         COND_RESET:      taken = cmd_ff;
         COND_TICKS_ZERO: taken = bad_ff;
         COND_DIV_MORE:   taken = !div_last;
         default:         taken = 1'b0;
      endcase
   end

   always_comb begin
      gain_prop_in   = gain_prop_ff;
      gain_integ_in  = gain_integ_ff;
      gain_deriv_in  = gain_deriv_ff;
      speed_scale_in = speed_scale_ff;
      last_count_in  = last_count_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      busy_in        = busy_ff;
      pc_in          = pc_ff;
      cmd_in         = cmd_ff;
      sel_ok_in      = sel_ok_ff;
      idx_in         = idx_ff;
      target_in      = target_ff;
      enc_in         = enc_ff;
      ticks_in       = ticks_ff;
      bad_in         = bad_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      err_in         = err_ff;
      sum_in         = sum_ff;
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_sat_in     = rsp_sat_ff;
      rsp_bad_in     = rsp_bad_ff;
      div_ctrl       = '0;
      advance        = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_GAIN_PROP:   gain_prop_in   = csr_wdata[15:0];
            CSR_GAIN_INTEG:  gain_integ_in  = csr_wdata[15:0];
            CSR_GAIN_DERIV:  gain_deriv_in  = csr_wdata[15:0];
            CSR_SPEED_SCALE: speed_scale_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (req_accept) begin
         busy_in   = 1'b1;
         pc_in     = '0;
         cmd_in    = req_command;
         sel_ok_in = sel_ext < MOTOR_LIMIT;
         idx_in    = sel_ext[IDX_W-1:0];
         target_in = req_target_speed;
         enc_in    = req_encoder_count;
         ticks_in  = req_elapsed_ticks;
         bad_in    = req_elapsed_ticks == 24'd0;
         sat_in    = 1'b0;
      end else if (busy_ff) begin
         // Finishing steps wait until the output register can take the result.
         advance = !cw.last || out_free;
         if (advance) begin
            pc_in = taken ? cw.target : pc_ff + 1'b1;
            if (cw.last) begin
               busy_in = 1'b0;
            end
            case (cw.op)
               OP_DELTA: begin
                  neg_in = delta[31];
                  mag_in = delta[31] ? (~delta + 32'd1) : delta;
               end
               OP_MUL_SCALE: begin
                  prod_in = mul_p;
               end
               OP_DIV_INIT: begin
                  div_ctrl.init = 1'b1;
               end
               OP_DIV_STEP: begin
                  div_ctrl.step = 1'b1;
               end
               OP_ERR: begin
                  if (err_raw < -21'sd65536) begin
                     err_in = 17'sh10000;
                     sat_in = 1'b1;
                  end else if (err_raw > 21'sd65535) begin
                     err_in = 17'sh0FFFF;
                     sat_in = 1'b1;
                  end else begin
                     err_in = err_raw[16:0];
                  end
               end
               OP_SUM: begin
                  if (sum_raw[32] != sum_raw[31]) begin
                     sum_in = sum_raw[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                     sat_in = 1'b1;
                  end else begin
                     sum_in = sum_raw[31:0];
                  end
               end
               OP_MUL_P: begin
                  prod_in = mul_p;
               end
               OP_MUL_I: begin
                  acc_in  = prod_ff[49:0];
                  prod_in = mul_p;
               end
               OP_MUL_D: begin
                  acc_in  = acc_sum;
                  prod_in = mul_p;
               end
               OP_ACC: begin
                  acc_in = acc_sum;
               end
               OP_ROUND: begin
                  acc_in = acc_ff + 50'sd2048;
               end
               OP_FINISH: begin
                  error_sum_in[idx_ff]  = sum_ff;
                  last_error_in[idx_ff] = err_ff;
                  last_count_in[idx_ff] = enc_ff;
                  rsp_valid_in = 1'b1;
                  rsp_drive_in = drive_sat;
                  rsp_sat_in   = sat_ff | drive_clamped;
                  rsp_bad_in   = bad_ff;
               end
               OP_CLEAR: begin
                  error_sum_in[idx_ff]  = '0;
                  last_error_in[idx_ff] = '0;
                  last_count_in[idx_ff] = enc_ff;
                  rsp_valid_in = 1'b1;
                  rsp_drive_in = '0;
                  rsp_sat_in   = 1'b0;
                  rsp_bad_in   = 1'b0;
               end
               OP_IGNORE: begin
                  rsp_valid_in = 1'b1;
                  rsp_drive_in = '0;
                  rsp_sat_in   = 1'b0;
                  rsp_bad_in   = 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= GAIN_PROP_RESET;
         gain_integ_ff  <= GAIN_INTEG_RESET;
         gain_deriv_ff  <= GAIN_DERIV_RESET;
         speed_scale_ff <= SPEED_SCALE_RESET;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            last_count_ff[i] <= '0;
            error_sum_ff[i]  <= '0;
            last_error_ff[i] <= '0;
         end
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_prop_ff   <= gain_prop_in;
         gain_integ_ff  <= gain_integ_in;
         gain_deriv_ff  <= gain_deriv_in;
         speed_scale_ff <= speed_scale_in;
         last_count_ff  <= last_count_in;
         error_sum_ff   <= error_sum_in;
         last_error_ff  <= last_error_in;
         busy_ff        <= busy_in;
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sel_ok_ff    <= sel_ok_in;
      idx_ff       <= idx_in;
      target_ff    <= target_in;
      enc_ff       <= enc_in;
      ticks_ff     <= ticks_in;
      bad_ff       <= bad_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      err_ff       <= err_in;
      sum_ff       <= sum_in;
      sat_ff       <= sat_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_speed = rsp_drive_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_bad_time    = rsp_bad_ff;

endmodule
